[hdl/sbps_pkg.sv]
`timescale 1ns / 1ps

package sbps_pkg;

	localparam int MaxPattern = 16;
	localparam int WinDepth   = MaxPattern - 1;
	localparam int FillW      = $clog2(WinDepth + 1);
	localparam int AddrW      = 48;
	localparam int LenW       = 5;
	localparam int BplW       = 9;
	localparam int CfgIdxW    = 3;
	localparam int CfgDataW   = 64;

	localparam logic [CfgIdxW-1:0] CfgPatternLow    = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgPatternHigh   = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgPatternLength = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgStartOffset   = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgBytesPerLine  = 3'd4;

	typedef logic [MaxPattern-1:0][7:0] sbps_pattern_t;

	// Stream position as seen by the current item, after any restart.
	typedef struct packed {
		logic [WinDepth-1:0][7:0]       bytes;
		logic [WinDepth-1:0][AddrW-1:0] tags;
		logic [FillW-1:0]               fill;
		logic [AddrW-1:0]               index;
		logic [AddrW-1:0]               line;
	} sbps_view_t;

endpackage

[hdl/sbps_window.sv]
`timescale 1ns / 1ps

module sbps_window import sbps_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            first,
	input  logic [7:0]      data_byte,
	input  logic [BplW-1:0] bpl_eff,
	output sbps_view_t      view
);

	logic [WinDepth-1:0][7:0]       bytes_q;
	logic [WinDepth-1:0][AddrW-1:0] tags_q;
	logic [FillW-1:0]               fill_q;
	logic [AddrW-1:0]               index_q;
	logic [7:0]                     column_q;
	logic [AddrW-1:0]               line_q;
	logic [7:0]                     column_eff;
	logic [8:0]                     column_inc;

	// Slots beyond the fill count never decide a match, so a restart only clears the counters.
	always_comb begin
		view.bytes = bytes_q;
		view.tags  = tags_q;
		view.fill  = first ? '0 : fill_q;
		view.index = first ? '0 : index_q;
		view.line  = first ? '0 : line_q;
		column_eff = first ? '0 : column_q;
		column_inc = {1'b0, column_eff} + 9'd1;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bytes_q[0] <= data_byte;
			tags_q[0]  <= view.line;
			for (int k = 1; k < WinDepth; k++) begin
				bytes_q[k] <= bytes_q[k-1];
				tags_q[k]  <= tags_q[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			index_q  <= '0;
			column_q <= '0;
			line_q   <= '0;
		end else if (advance) begin
			if (view.fill != FillW'(WinDepth)) begin
				fill_q <= view.fill + FillW'(1);
			end else begin
				fill_q <= view.fill;
			end
			index_q <= view.index + AddrW'(1);
			if (column_inc >= bpl_eff) begin
				column_q <= '0;
				line_q   <= view.line + AddrW'(1);
			end else begin
				column_q <= column_inc[7:0];
				line_q   <= view.line;
			end
		end
	end

endmodule

[hdl/sbps_match.sv]
`timescale 1ns / 1ps

module sbps_match import sbps_pkg::*; (
	input  sbps_view_t       view,
	input  logic [7:0]       data_byte,
	input  sbps_pattern_t    pattern,
	input  logic [LenW-1:0]  len_eff,
	input  logic [AddrW-1:0] start_offset,
	output logic             hit,
	output logic [AddrW-1:0] address,
	output logic [AddrW-1:0] line
);

	logic [LenW-1:0]     len_m1;
	logic [LenW-1:0]     len_m2;
	logic [LenW-1:0]     pidx;
	logic [WinDepth-1:0] slot_ok;

	always_comb begin
		len_m1 = len_eff - LenW'(1);
		len_m2 = len_eff - LenW'(2);
		pidx   = '0;
		for (int j = 0; j < WinDepth; j++) begin
			pidx = len_m2 - LenW'(j);
			if (LenW'(j) >= len_m1) begin
				slot_ok[j] = 1'b1;
			end else begin
				slot_ok[j] = (view.bytes[j] == pattern[pidx[3:0]]);
			end
		end
		hit = (len_eff != '0) && ({1'b0, view.fill} >= len_m1) &&
		      (pattern[len_m1[3:0]] == data_byte) && (&slot_ok);
		address = start_offset + view.index - AddrW'(len_m1);
		if (len_eff > LenW'(1)) begin
			line = view.tags[len_m2[3:0]];
		end else begin
			line = view.line;
		end
	end

endmodule

[hdl/streaming_byte_pattern_search_core.sv]
`timescale 1ns / 1ps

// Searches a byte stream for a pattern of 1 to 16 bytes, one byte per item and one item per
// clock cycle, overlapping matches included. Each byte is compared in parallel against a shift
// window of the previous 15 bytes, and a match is reported in the cycle after its last byte is
// accepted, with the absolute address of its first byte and the line index of that byte. The
// result register is emptied and refilled at the same edge, so throughput is one item per
// cycle as long as results are taken; input stall is raised only while a held result is stalled.
// An item with first set restarts addresses and line counting at that byte.
module streaming_byte_pattern_search_core import sbps_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                first,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [AddrW-1:0]    match_address,
	output logic [AddrW-1:0]    match_line
);

	logic [63:0]       pattern_low_q;
	logic [63:0]       pattern_high_q;
	logic [LenW-1:0]   pattern_length_q;
	logic [AddrW-1:0]  start_offset_q;
	logic [BplW-1:0]   bytes_per_line_q;
	logic [LenW-1:0]   len_eff;
	logic [BplW-1:0]   bpl_eff;
	logic              accept;
	sbps_view_t        view;
	logic              hit;
	logic [AddrW-1:0]  hit_address;
	logic [AddrW-1:0]  hit_line;
	logic              out_valid_q;
	logic [AddrW-1:0]  match_address_q;
	logic [AddrW-1:0]  match_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			pattern_length_q <= LenW'(1);
			start_offset_q   <= '0;
			bytes_per_line_q <= BplW'(16);
		end else if (cfg_write_en) begin
			case (cfg_index)
				CfgPatternLow:    pattern_low_q    <= cfg_data;
				CfgPatternHigh:   pattern_high_q   <= cfg_data;
				CfgPatternLength: pattern_length_q <= cfg_data[LenW-1:0];
				CfgStartOffset:   start_offset_q   <= cfg_data[AddrW-1:0];
				CfgBytesPerLine:  bytes_per_line_q <= cfg_data[BplW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		len_eff = (pattern_length_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : pattern_length_q;
		if (bytes_per_line_q == '0) begin
			bpl_eff = BplW'(1);
		end else if (bytes_per_line_q > BplW'(256)) begin
			bpl_eff = BplW'(256);
		end else begin
			bpl_eff = bytes_per_line_q;
		end
	end

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	sbps_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (accept),
		.first     (first),
		.data_byte (data_byte),
		.bpl_eff   (bpl_eff),
		.view      (view)
	);

	sbps_match u_match (
		.view         (view),
		.data_byte    (data_byte),
		.pattern      ({pattern_high_q, pattern_low_q}),
		.len_eff      (len_eff),
		.start_offset (start_offset_q),
		.hit          (hit),
		.address      (hit_address),
		.line         (hit_line)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= hit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			match_address_q <= hit_address;
			match_line_q    <= hit_line;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;
	assign match_line    = match_line_q;

endmodule

[hdl/sbps_checker.sv]
`timescale 1ns / 1ps

module sbps_checker import sbps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [AddrW-1:0] match_address,
	input  logic [AddrW-1:0] match_line
);

	// Input is held back only by a result that is waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting result");

	// With no item taken and the result side free, no result can appear.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && !in_stall) && !out_stall) |=> !out_valid)
		else $error("result appeared without an accepted item");

	// A result that is not taken stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(match_address) &&
		                             $stable(match_line)))
		else $error("stalled result changed or vanished");

endmodule

bind streaming_byte_pattern_search_core sbps_checker u_sbps_checker (.*);

[test/streaming_byte_pattern_search_core_test.sv]
`timescale 1ns / 1ps

module streaming_byte_pattern_search_core_test;
	import sbps_pkg::*;

	localparam int CycleLimit  = 800000;
	localparam int RandPhases  = 14;
	localparam int PhaseItems  = 130;
	localparam int SettleLimit = 5000;

	logic                clk;
	logic                arst_n;
	logic                cfg_write_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          data_byte;
	logic                first;
	logic                out_valid;
	logic                out_stall;
	logic [AddrW-1:0]    match_address;
	logic [AddrW-1:0]    match_line;

	int cycle_count;
	int steady_left;
	int settings_used;

	streaming_byte_pattern_search_core DUT (.*);

	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [AddrW-1:0] line;
	} match_t;

	// Tracks the stream position and pattern, and holds the matches still owed by the block.
	class match_tracker;
		logic [63:0]      pat_lo;
		logic [63:0]      pat_hi;
		logic [LenW-1:0]  len_reg;
		logic [AddrW-1:0] offset_reg;
		logic [BplW-1:0]  bpl_reg;
		logic [7:0]       win_bytes [WinDepth];
		logic [AddrW-1:0] win_lines [WinDepth];
		int               fill;
		int               column;
		logic [AddrW-1:0] rel_index;
		logic [AddrW-1:0] line_cnt;
		match_t           matches_due [$];
		int               mismatches;
		int               matches_seen;
		int               bytes_fed;

		function new();
			pat_lo = '0;
			pat_hi = '0;
			len_reg = 1;
			offset_reg = '0;
			bpl_reg = 16;
			mismatches = 0;
			matches_seen = 0;
			bytes_fed = 0;
			clear_stream();
		endfunction

		function void clear_stream();
			for (int k = 0; k < WinDepth; k++) begin
				win_bytes[k] = '0;
				win_lines[k] = '0;
			end
			fill = 0;
			column = 0;
			rel_index = '0;
			line_cnt = '0;
		endfunction

		function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
			case (idx)
				CfgPatternLow: pat_lo = data;
				CfgPatternHigh: pat_hi = data;
				CfgPatternLength: len_reg = data[LenW-1:0];
				CfgStartOffset: offset_reg = data[AddrW-1:0];
				CfgBytesPerLine: bpl_reg = data[BplW-1:0];
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, logic restart);
			int               n;
			int               bpl;
			bit               ok;
			logic [127:0]     pat;
			logic [AddrW-1:0] line_now;
			match_t           hit;
			if (restart)
				clear_stream();
			bytes_fed++;
			n = (len_reg > MaxPattern) ? MaxPattern : int'(len_reg);
			bpl = (bpl_reg == 0) ? 1 : ((bpl_reg > 256) ? 256 : int'(bpl_reg));
			pat = {pat_hi, pat_lo};
			line_now = line_cnt;
			if (n >= 1 && fill >= n - 1 && pat[8 * (n - 1) +: 8] == b) begin
				ok = 1'b1;
				for (int k = 1; k < n; k++)
					if (win_bytes[k - 1] != pat[8 * (n - 1 - k) +: 8])
						ok = 1'b0;
				if (ok) begin
					hit.addr = offset_reg + (rel_index - AddrW'(n - 1));
					hit.line = (n > 1) ? win_lines[n - 2] : line_now;
					matches_due.push_back(hit);
				end
			end
			for (int k = WinDepth - 1; k > 0; k--) begin
				win_bytes[k] = win_bytes[k - 1];
				win_lines[k] = win_lines[k - 1];
			end
			win_bytes[0] = b;
			win_lines[0] = line_now;
			if (fill < WinDepth)
				fill++;
			rel_index = rel_index + 1'b1;
			if (column + 1 >= bpl) begin
				column = 0;
				line_cnt = line_cnt + 1'b1;
			end else begin
				column = (column + 1) & 255;
			end
		endfunction

		function void check_match(logic [AddrW-1:0] addr, logic [AddrW-1:0] line);
			match_t want;
			matches_seen++;
			if (matches_due.size() == 0) begin
				$display("%0t: unexpected match, expected none, got address %h line %h",
					$time, addr, line);
				mismatches++;
				return;
			end
			want = matches_due.pop_front();
			if (addr !== want.addr) begin
				$display("%0t: match_address expected %h, got %h", $time, want.addr, addr);
				mismatches++;
			end
			if (line !== want.line) begin
				$display("%0t: match_line expected %h, got %h", $time, want.line, line);
				mismatches++;
			end
		endfunction
	endclass

	match_tracker tracker = new();

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.check_match(match_address, match_line);
			if (in_valid && !in_stall)
				tracker.note_byte(data_byte, first);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 94)
			return $urandom_range(4, 9);
		return $urandom_range(12, 40);
	endfunction

	function automatic int next_idle();
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		if ($urandom_range(0, 99) < 4) begin
			steady_left = $urandom_range(20, 80);
			return 0;
		end
		return ($urandom_range(0, 1) == 0) ? 0 : pick_gap();
	endfunction

	// Sets bits above a register's width now and then; the block must ignore them.
	function automatic logic [63:0] pad_word(logic [63:0] v, int w);
		logic [63:0] noise;
		noise = {$urandom, $urandom};
		if ($urandom_range(0, 3) == 0)
			return v | (noise << w);
		return v;
	endfunction

	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 6))
				@(negedge clk);
			out_stall <= 1'b1;
			repeat (pick_gap()) @(negedge clk);
			out_stall <= 1'b0;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run timed out after %0d cycles.", cycle_count);
		$display("** streaming_byte_pattern_search_core: FAILED **");
		$finish;
	end

	task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
		input logic [63:0] len_word, input logic [63:0] off_word, input logic [63:0] bpl_word);
		logic [CfgIdxW-1:0] order [5];
		logic [63:0]        words [5];
		order = '{CfgPatternLow, CfgPatternHigh, CfgPatternLength, CfgStartOffset, CfgBytesPerLine};
		words = '{lo, hi, len_word, off_word, bpl_word};
		for (int i = 0; i < 5; i++) begin
			cfg_write_en <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= words[i];
			tracker.write_reg(order[i], words[i]);
			@(negedge clk);
		end
		cfg_write_en <= 1'b0;
		settings_used++;
	endtask

	task automatic put_byte(input logic [7:0] b, input logic f);
		int idle;
		idle = next_idle();
		if (idle > 0) begin
			in_valid <= 1'b0;
			data_byte <= 8'($urandom);
			first <= 1'($urandom);
			repeat (idle) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first <= f;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (tracker.matches_due.size() != 0 && waited < SettleLimit) begin
			@(negedge clk);
			waited++;
		end
		repeat (8) @(negedge clk);
		if (tracker.matches_due.size() != 0) begin
			$display("%0t: %0d expected matches never arrived, first expected address %h line %h",
				$time, tracker.matches_due.size(), tracker.matches_due[0].addr,
				tracker.matches_due[0].line);
			tracker.mismatches++;
			tracker.matches_due.delete();
		end
	endtask

	initial begin
		logic [7:0]   dir_bytes [11];
		logic         dir_first [11];
		logic [127:0] cur_pat;
		logic [63:0]  len_val;
		logic [63:0]  bpl_val;
		logic [63:0]  off_val;
		logic [7:0]   sym_a;
		logic [7:0]   sym_b;
		logic [7:0]   b;
		int           eff_len;
		int           sent;
		int           pick;
		int           bad_pos;
		int           slot;

		arst_n = 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index <= CfgPatternLow;
		cfg_data <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		first <= 1'b0;
		steady_left = 0;
		settings_used = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Three-byte pattern near the top of the address space, one byte per line,
		// overlapping matches and a restart inside a partial match.
		dir_bytes = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h7F, 8'h80};
		dir_first = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
		configure(64'h0000_0000_00FF_00FF, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3,
			64'h0000_FFFF_FFFF_FFFE, 64'd1);
		for (int i = 0; i < 11; i++)
			put_byte(dir_bytes[i], dir_first[i]);
		drain();

		// An oversized length acts as the full sixteen bytes, and a zero line length as one.
		cur_pat = {$urandom, $urandom, $urandom, $urandom};
		configure(cur_pat[63:0], cur_pat[127:64], 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FE00);
		for (int k = 0; k < MaxPattern; k++)
			put_byte(cur_pat[8 * k +: 8], k == 0);
		drain();

		for (int phase = 0; phase < RandPhases; phase++) begin
			off_val = 64'({$urandom, $urandom}) & 64'h0000_FFFF_FFFF_FFFF;
			case (phase)
				0: begin
					len_val = 1;
					bpl_val = 256;
					off_val = 64'h0000_FFFF_FFFF_FF80;
				end
				1: begin
					len_val = 16;
					bpl_val = 1;
					off_val = 0;
				end
				2: begin
					len_val = 0;
					bpl_val = 0;
					off_val = 64'h0000_FFFF_FFFF_FFFF;
				end
				3: begin
					len_val = 2;
					bpl_val = 511;
				end
				4: begin
					len_val = $urandom_range(17, 31);
					bpl_val = 255;
				end
				5: begin
					len_val = $urandom_range(1, 16);
					bpl_val = $urandom_range(257, 510);
				end
				default: begin
					len_val = $urandom_range(1, 16);
					bpl_val = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8)
						: $urandom_range(1, 256);
				end
			endcase

			sym_a = $urandom;
			sym_b = $urandom;
			for (int k = 0; k < MaxPattern; k++) begin
				case (phase % 3)
					0: cur_pat[8 * k +: 8] = $urandom;
					1: cur_pat[8 * k +: 8] = ($urandom_range(0, 1) == 0) ? sym_a : sym_b;
					default: cur_pat[8 * k +: 8] = sym_a;
				endcase
			end
			configure(cur_pat[63:0], cur_pat[127:64], pad_word(len_val, LenW),
				pad_word(off_val, AddrW), pad_word(bpl_val, BplW));
			eff_len = (len_val > MaxPattern) ? MaxPattern : int'(len_val);

			sent = 0;
			while (sent < PhaseItems) begin
				pick = $urandom_range(0, 99);
				if (eff_len > 0 && pick < 55) begin
					bad_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, eff_len - 1) : -1;
					for (int k = 0; k < eff_len; k++) begin
						b = cur_pat[8 * k +: 8];
						if (k == bad_pos)
							b = b ^ 8'(1 << $urandom_range(0, 7));
						put_byte(b, k == 0 && $urandom_range(0, 19) == 0);
						sent++;
					end
				end else begin
					slot = $urandom_range(0, MaxPattern - 1);
					b = (pick < 85) ? cur_pat[8 * slot +: 8] : 8'($urandom);
					put_byte(b, $urandom_range(0, 39) == 0);
					sent++;
				end
			end
			drain();
		end

		$display("Fed %0d bytes through %0d register settings, including degenerate lengths,",
			tracker.bytes_fed, settings_used);
		$display("address wrap and mid-stream line length changes; %0d matches checked.",
			tracker.matches_seen);
		if (tracker.mismatches == 0)
			$display("** streaming_byte_pattern_search_core: PASSED **");
		else
			$display("** streaming_byte_pattern_search_core: FAILED **");
		$finish;
	end

endmodule

[streaming_byte_pattern_search_core.f]
hdl/sbps_pkg.sv
hdl/sbps_window.sv
hdl/sbps_match.sv
hdl/streaming_byte_pattern_search_core.sv
hdl/sbps_checker.sv
test/streaming_byte_pattern_search_core_test.sv
